### hdl/sfp_pkg.sv
// ----------------------------------------------------------------------------
// sfp_pkg
// Shared widths, codes and types for the sensor frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package sfp_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned LEVEL_W     = 16;
   localparam int unsigned FRAME_LEN   = 9;
   localparam int unsigned PAYLOAD_LEN = 6;
   localparam int unsigned POS_W       = 4;
   localparam int unsigned IDX_W       = 3;
   localparam int unsigned CSR_IDX_W   = 2;
   localparam int unsigned QUEUE_DEPTH = 4;

   localparam logic [BYTE_W-1:0] HEADER_FIRST_RST  = 8'h2c;
   localparam logic [BYTE_W-1:0] HEADER_SECOND_RST = 8'he4;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_FIRST  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_SECOND = 2'd1;

   // What a queued byte means to the back end
   typedef logic [1:0] kind_type;
   localparam kind_type KIND_HEADER  = 2'd0;
   localparam kind_type KIND_PAYLOAD = 2'd1;
   localparam kind_type KIND_CHECK   = 2'd2;

   typedef struct packed {
      kind_type              kind;
      logic [IDX_W-1:0]      idx;
      logic [BYTE_W-1:0]     data;
   } entry_type;

   typedef struct packed {
      logic [BYTE_W-1:0] header_first;
      logic [BYTE_W-1:0] header_second;
   } hdr_cfg_type;

   typedef struct packed {
      logic full;
      logic push;
      logic pop;
   } queue_status_type;

endpackage

`default_nettype wire

### hdl/sfp_front.sv
// ----------------------------------------------------------------------------
// sfp_front
// Header hunt and byte classification; pushes frame bytes into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sfp_front (
   input  wire                          clock,
   input  wire                          reset,
   input  sfp_pkg::hdr_cfg_type         cfg,
   input  wire                          req_valid,
   input  wire [sfp_pkg::BYTE_W-1:0]    req_byte,
   input  wire                          q_full,
   output logic                         req_ready,
   output logic                         push_valid,
   output sfp_pkg::entry_type           push_entry
);
   import sfp_pkg::*;

   logic [POS_W-1:0]  pos_ff;
   logic [POS_W-1:0]  pos_in;
   logic [POS_W-1:0]  pos_next;
   logic [POS_W-1:0]  hunt_pos;
   logic [BYTE_W-1:0] first_ff;
   logic [BYTE_W-1:0] first_in;
   logic              push_req;
   logic              accept;

   assign req_ready = !q_full;
   assign accept    = req_valid && !q_full;
   assign hunt_pos  = (req_byte == cfg.header_first) ? POS_W'(1) : POS_W'(0);

   always_comb begin
      pos_next        = pos_ff;
      push_req        = 1'b0;
      push_entry.kind = KIND_PAYLOAD;
      push_entry.idx  = IDX_W'(pos_ff - POS_W'(2));
      push_entry.data = req_byte;
      if (pos_ff == POS_W'(0) || pos_ff >= POS_W'(FRAME_LEN)) begin
         pos_next = hunt_pos;
      end else if (pos_ff == POS_W'(1)) begin
         if (req_byte != cfg.header_second) begin
            pos_next = hunt_pos;
         end else begin
            // seed the back end's sum with both header bytes
            push_req        = 1'b1;
            push_entry.kind = KIND_HEADER;
            push_entry.data = first_ff + req_byte;
            pos_next        = POS_W'(2);
         end
      end else if (pos_ff < POS_W'(FRAME_LEN - 1)) begin
         push_req = 1'b1;
         pos_next = pos_ff + POS_W'(1);
      end else begin
         push_req        = 1'b1;
         push_entry.kind = KIND_CHECK;
         pos_next        = POS_W'(0);
      end
   end

   assign push_valid = accept && push_req;
   assign pos_in     = accept ? pos_next : pos_ff;
   // hold the first header byte as it was received
   assign first_in   = (accept && pos_next == POS_W'(1)) ? req_byte : first_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         first_ff <= '0;
      end else begin
         pos_ff   <= pos_in;
         first_ff <= first_in;
      end
   end

endmodule

`default_nettype wire

### hdl/sfp_queue.sv
// ----------------------------------------------------------------------------
// sfp_queue
// Small FIFO of classified bytes between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module sfp_queue #(
   parameter int unsigned DEPTH = sfp_pkg::QUEUE_DEPTH
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push,
   input  sfp_pkg::entry_type   push_entry,
   input  wire                  pop,
   output logic                 head_valid,
   output sfp_pkg::entry_type   head_entry,
   output logic                 full
);
   import sfp_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   entry_type        slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   assign head_valid = (count_ff != '0);
   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_entry = slot_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in = count_ff + CNT_W'(push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

### hdl/sfp_back.sv
// ----------------------------------------------------------------------------
// sfp_back
// Checksum accumulation, payload capture and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sfp_back (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            head_valid,
   input  sfp_pkg::entry_type             head_entry,
   output logic                           pop,
   output logic                           rsp_valid,
   input  wire                            rsp_ready,
   output logic                           rsp_status,
   output logic [4*sfp_pkg::LEVEL_W-1:0]  rsp_levels
);
   import sfp_pkg::*;

   logic [BYTE_W-1:0]    sum_ff, sum_in;
   logic [BYTE_W-1:0]    payload_ff [PAYLOAD_LEN];
   logic [LEVEL_W-1:0]   failures_ff, failures_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 status_ff;
   logic [4*LEVEL_W-1:0] levels_ff;
   logic                 slot_free;
   logic                 is_check;
   logic                 bad;
   logic [3*LEVEL_W-1:0] readings;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign is_check  = (head_entry.kind == KIND_CHECK);
   assign pop       = head_valid && (!is_check || slot_free);
   assign bad       = (sum_ff != head_entry.data);
   assign readings  = {payload_ff[4], payload_ff[5], payload_ff[2], payload_ff[3],
                       payload_ff[0], payload_ff[1]};

   always_comb begin
      sum_in       = sum_ff;
      failures_in  = failures_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (pop) begin
         case (head_entry.kind)
            KIND_HEADER:  sum_in = head_entry.data;
            KIND_PAYLOAD: sum_in = sum_ff + head_entry.data;
            KIND_CHECK: begin
               rsp_valid_in = 1'b1;
               if (bad && !(&failures_ff)) begin
                  failures_in = failures_ff + LEVEL_W'(1);
               end
            end
            default: sum_in = sum_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (pop && head_entry.kind == KIND_PAYLOAD && head_entry.idx < IDX_W'(PAYLOAD_LEN)) begin
         payload_ff[head_entry.idx] <= head_entry.data;
      end
      if (pop && is_check) begin
         status_ff <= bad;
         levels_ff <= {failures_in, bad ? (3*LEVEL_W)'(0) : readings};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         failures_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         failures_ff  <= failures_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_levels = levels_ff;

endmodule

`default_nettype wire

### hdl/sensor_frame_parser.sv
// A result is offered once its checksum byte has passed a queue slot and the
// result valid register. Throughput: one received byte per cycle while the
// queue is not full; the front end, queue and back end each move one byte a
// cycle unless stalled, and the result register lets the next frame proceed
// while a result waits. Reset clears position, queue, sum, failure count and
// result valid, and loads the header registers with 0x2c and 0xe4.
// ----------------------------------------------------------------------------
// sensor_frame_parser
// Byte-serial parser for a nine-byte sensor frame with a two-byte header and
// an eight-bit additive checksum.
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_frame_parser #(
   parameter int unsigned QUEUE_DEPTH = sfp_pkg::QUEUE_DEPTH
) (
   input  wire                              clock,
   input  wire                              reset,
   // byte stream in
   input  wire                              req_tvalid,
   output logic                             req_tready,
   input  wire [sfp_pkg::BYTE_W-1:0]        req_tdata,  // [7:0] rx_byte
   // frame results out
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   output logic [4*sfp_pkg::LEVEL_W-1:0]    rsp_tdata,  // [15:0] tvoc_level,
                                                        // [31:16] formaldehyde_level,
                                                        // [47:32] co2_level,
                                                        // [63:48] failure_count
   output logic                             rsp_tuser,  // [0] frame_status
   // register writes
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire [sfp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire [sfp_pkg::BYTE_W-1:0]        csr_data
);
   import sfp_pkg::*;

   hdr_cfg_type      hdr_ff, hdr_in;
   entry_type        push_entry;
   entry_type        head_entry;
   logic             head_valid;
   queue_status_type q_stat;

   // Header registers: always ready, unknown indexes are dropped
   assign csr_ready = 1'b1;

   always_comb begin
      hdr_in = hdr_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_HEADER_FIRST:  hdr_in.header_first  = csr_data;
            CSR_HEADER_SECOND: hdr_in.header_second = csr_data;
            default:           hdr_in = hdr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_ff.header_first  <= HEADER_FIRST_RST;
         hdr_ff.header_second <= HEADER_SECOND_RST;
      end else begin
         hdr_ff <= hdr_in;
      end
   end

   // Front end: hunt for the header and tag each frame byte from the second header byte on
   sfp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (hdr_ff),
      .req_valid  (req_tvalid),
      .req_byte   (req_tdata),
      .q_full     (q_stat.full),
      .req_ready  (req_tready),
      .push_valid (q_stat.push),
      .push_entry (push_entry)
   );

   // Queue: decouple the byte intake from result back-pressure
   sfp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_stat.push),
      .push_entry (push_entry),
      .pop        (q_stat.pop),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .full       (q_stat.full)
   );

   // Back end: sum, capture payload, check and hold the result
   sfp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (q_stat.pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_status (rsp_tuser),
      .rsp_levels (rsp_tdata)
   );

`ifndef SYNTHESIS
   // Never write into a full queue
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_stat.push |-> !q_stat.full)
      else $error("push into full queue");

   // A failed checksum carries zero readings
   a_bad_frame_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[3*LEVEL_W-1:0] == '0))
      else $error("readings not cleared on checksum mismatch");

   // A failed frame result shows a non-zero failure count
   a_bad_frame_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[4*LEVEL_W-1:3*LEVEL_W] != '0))
      else $error("failure count zero on mismatch");

   // Only a pending byte is ever taken from the queue
   a_pop_needs_head: assert property (@(posedge clock) disable iff (reset)
      q_stat.pop |-> head_valid)
      else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire
